### hdl/lcws_pkg.sv
// ----------------------------------------------------------------------------
// lcws_pkg
// Types, constants and the control store of the LED channel write sequencer.
// ----------------------------------------------------------------------------
package lcws_pkg;

  localparam int NUM_CHANNELS = 24;
  localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [5:0] CH_LIMIT = 6'(NUM_CHANNELS);

  localparam logic [7:0] REG_DUTY0    = 8'h0A;
  localparam logic [7:0] REG_MODE0    = 8'h02;
  localparam logic [7:0] REG_IREF_ALL = 8'h40;
  localparam logic [7:0] RESET_BYTE   = 8'h06;
  localparam logic [6:0] GENERAL_CALL = 7'h00;
  localparam logic [7:0] FULL_LEVEL   = 8'hFF;

  typedef enum logic [2:0] {
    OP_INIT  = 3'd0,
    OP_LEVEL = 3'd1,
    OP_ON    = 3'd2,
    OP_OFF   = 3'd3,
    OP_TICK  = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    MODE_OFF = 2'd0,
    MODE_ON  = 2'd1,
    MODE_PWM = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_RESET  = 2'd1,
    KIND_FULL   = 2'd2,
    KIND_MASKED = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CHAN = 2'd1,
    ST_BUSY     = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_ON   = 2'd1,
    PEND_OFF  = 2'd2
  } pend_e;

  typedef enum logic [1:0] {
    CFG_DEVICE_ADDRESS = 2'd0,
    CFG_RAMP_PERIOD    = 2'd1,
    CFG_CURRENT_SCALE  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0] opcode;
    logic [4:0] channel;
    logic [7:0] level;
  } cmd_t;

  typedef struct packed {
    logic [1:0] write_kind;
    logic [6:0] bus_address;
    logic [7:0] register_address;
    logic [7:0] write_data;
    logic [7:0] write_mask;
    logic [1:0] status;
    logic       last;
  } res_t;

  // micro-operations
  typedef enum logic [4:0] {
    A_NOP,
    A_EMIT_ST0,
    A_EMIT_ST1,
    A_EMIT_ST2,
    A_EMIT_RESET,
    A_EMIT_IREF,
    A_EMIT_DUTY_V,
    A_SET_PWM,
    A_EMIT_DUTY_TGT,
    A_RAMP_START,
    A_RAMP_STEP,
    A_SET_MODE,
    A_TICK_INC,
    A_TICK_WRAP,
    A_RAMP_END,
    A_RAMP_ABORT,
    A_FINISH
  } act_e;

  // jump conditions
  typedef enum logic [4:0] {
    C_NEXT,
    C_ALWAYS,
    C_OP_TICK,
    C_OP_BAD,
    C_CH_BAD_CMD,
    C_RAMP_ACTIVE,
    C_OP_INIT,
    C_LVL_EQ_TGT,
    C_MODE_PWM,
    C_PERIOD_ZERO,
    C_OP_LEVEL,
    C_MODE_EQ_FM,
    C_EMITTED,
    C_RAMP_IDLE,
    C_TICK_SHORT,
    C_CH_BAD,
    C_PEND_NONE
  } cond_e;

  typedef logic [5:0] step_t;

  localparam step_t S_DISPATCH = 6'd0;
  localparam step_t S_PERIOD   = 6'd9;
  localparam step_t S_DIRECT   = 6'd12;
  localparam step_t S_NOSTART  = 6'd13;
  localparam step_t S_FIN      = 6'd16;
  localparam step_t S_ERR_CH   = 6'd18;
  localparam step_t S_ERR_BUSY = 6'd19;
  localparam step_t S_INIT     = 6'd20;
  localparam step_t S_TICK     = 6'd22;
  localparam step_t S_END      = 6'd29;
  localparam step_t S_ABORT    = 6'd32;
  localparam step_t S_DONE     = 6'd33;

  typedef struct packed {
    act_e  act;
    cond_e cond;
    step_t target;
  } uc_word_t;

  function automatic uc_word_t uc_rom(input step_t pc);
    uc_word_t w;
    case (pc)
      6'd0:  w = '{A_NOP,           C_OP_TICK,     S_TICK};
      6'd1:  w = '{A_NOP,           C_OP_BAD,      S_DONE};
      6'd2:  w = '{A_NOP,           C_CH_BAD_CMD,  S_ERR_CH};
      6'd3:  w = '{A_NOP,           C_RAMP_ACTIVE, S_ERR_BUSY};
      6'd4:  w = '{A_NOP,           C_OP_INIT,     S_INIT};
      6'd5:  w = '{A_NOP,           C_LVL_EQ_TGT,  S_NOSTART};
      6'd6:  w = '{A_NOP,           C_MODE_PWM,    S_PERIOD};
      6'd7:  w = '{A_EMIT_DUTY_V,   C_NEXT,        S_DISPATCH};
      6'd8:  w = '{A_SET_PWM,       C_NEXT,        S_DISPATCH};
      6'd9:  w = '{A_NOP,           C_PERIOD_ZERO, S_DIRECT};
      6'd10: w = '{A_NOP,           C_LVL_EQ_TGT,  S_NOSTART};
      6'd11: w = '{A_RAMP_START,    C_ALWAYS,      S_FIN};
      6'd12: w = '{A_EMIT_DUTY_TGT, C_NEXT,        S_DISPATCH};
      6'd13: w = '{A_NOP,           C_OP_LEVEL,    S_FIN};
      6'd14: w = '{A_NOP,           C_MODE_EQ_FM,  S_FIN};
      6'd15: w = '{A_SET_MODE,      C_NEXT,        S_DISPATCH};
      6'd16: w = '{A_NOP,           C_EMITTED,     S_DONE};
      6'd17: w = '{A_EMIT_ST0,      C_ALWAYS,      S_DONE};
      6'd18: w = '{A_EMIT_ST1,      C_ALWAYS,      S_DONE};
      6'd19: w = '{A_EMIT_ST2,      C_ALWAYS,      S_DONE};
      6'd20: w = '{A_EMIT_RESET,    C_NEXT,        S_DISPATCH};
      6'd21: w = '{A_EMIT_IREF,     C_ALWAYS,      S_DONE};
      6'd22: w = '{A_NOP,           C_RAMP_IDLE,   S_DONE};
      6'd23: w = '{A_TICK_INC,      C_NEXT,        S_DISPATCH};
      6'd24: w = '{A_NOP,           C_TICK_SHORT,  S_DONE};
      6'd25: w = '{A_TICK_WRAP,     C_NEXT,        S_DISPATCH};
      6'd26: w = '{A_NOP,           C_CH_BAD,      S_ABORT};
      6'd27: w = '{A_NOP,           C_LVL_EQ_TGT,  S_END};
      6'd28: w = '{A_RAMP_STEP,     C_ALWAYS,      S_DONE};
      6'd29: w = '{A_RAMP_END,      C_PEND_NONE,   S_DONE};
      6'd30: w = '{A_NOP,           C_MODE_EQ_FM,  S_DONE};
      6'd31: w = '{A_SET_MODE,      C_ALWAYS,      S_DONE};
      6'd32: w = '{A_RAMP_ABORT,    C_ALWAYS,      S_DONE};
      6'd33: w = '{A_FINISH,        C_ALWAYS,      S_DONE};
      default: w = '{A_NOP,         C_ALWAYS,      S_DONE};
    endcase
    return w;
  endfunction

endpackage

### hdl/led_channel_write_sequencer.sv
// ----------------------------------------------------------------------------
// led_channel_write_sequencer
// Microcoded sequencer turning LED commands into driver-chip register writes.
// ----------------------------------------------------------------------------
//  channel   direction  signals                          flow control
//  command   in         start, cmd_i                     busy
//  result    out        res_valid_o, res_o               strobe, no stall
//  config    in         cfg_we_i, cfg_addr_i, cfg_wdata_i  always taken
//
//  One control-store step per cycle; a command keeps busy high for its whole
//  program path, and the next one is taken after that.
//  A result is held until the next one is made; the last one, with last set,
//  leaves in the same cycle that busy falls.
//  Reset clears all caches and registers at once; no clearing pass.
//  Results are strobes and cannot be stalled.
// ----------------------------------------------------------------------------
module led_channel_write_sequencer
  import lcws_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  cmd_t        cmd_i,
  output logic        res_valid_o,
  output res_t        res_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i
);

  logic [6:0]  dev_addr_q;
  logic [15:0] ramp_period_q;
  logic [7:0]  cur_scale_q;

  logic [7:0]  level_q [NUM_CHANNELS];
  logic [1:0]  mode_q  [NUM_CHANNELS];

  logic        ramp_active_q;
  logic [4:0]  ramp_ch_q;
  logic [7:0]  ramp_tgt_q;
  logic [1:0]  pend_q;
  logic [15:0] tick_q;

  logic        busy_q;
  step_t       pc_q;
  logic [2:0]  op_q;
  logic [4:0]  ch_q;
  logic [7:0]  tgt_q;
  logic [1:0]  fm_q;
  logic        emitted_q;

  res_t        hold_q;
  logic        hold_valid_q;
  res_t        res_q;
  logic        res_valid_q;

  uc_word_t    uw;
  logic        jump;
  logic        ch_ok;
  logic [CH_IDX_W-1:0] ch_idx;
  logic [7:0]  cur_lvl;
  logic [1:0]  cur_mode;
  logic [7:0]  direct_v;
  logic [7:0]  step_lvl;
  logic [1:0]  set_m;
  logic [2:0]  mode_sh;
  logic [7:0]  duty_reg;
  logic [7:0]  mode_reg;

  logic        emit_en;
  res_t        emit_rec;
  logic        lvl_we;
  logic [7:0]  lvl_wd;
  logic        mode_we;
  logic [1:0]  mode_wd;
  logic        clear_all;

  logic        accept;
  logic        flush;
  res_t        last_rec;

  assign accept = start && !busy_q;
  assign uw     = uc_rom(pc_q);
  assign flush  = busy_q && hold_valid_q && (emit_en || (uw.act == A_FINISH));

  always_comb begin
    last_rec      = hold_q;
    last_rec.last = 1'b1;
  end

  assign ch_ok    = ({1'b0, ch_q} < CH_LIMIT);
  assign ch_idx   = ch_q[CH_IDX_W-1:0];
  assign cur_lvl  = ch_ok ? level_q[ch_idx] : 8'h00;
  assign cur_mode = ch_ok ? mode_q[ch_idx] : MODE_PWM;
  assign direct_v = (cur_mode == MODE_ON) ? FULL_LEVEL : 8'h00;
  assign step_lvl = (cur_lvl > tgt_q) ? (cur_lvl - 8'd1) : (cur_lvl + 8'd1);
  assign set_m    = (uw.act == A_SET_PWM) ? MODE_PWM : fm_q;
  assign mode_sh  = {ch_q[1:0], 1'b0};
  assign duty_reg = REG_DUTY0 + {3'b000, ch_q};
  assign mode_reg = REG_MODE0 + {5'b00000, ch_q[4:2]};

  always_comb begin
    case (uw.cond)
      C_NEXT:        jump = 1'b0;
      C_ALWAYS:      jump = 1'b1;
      C_OP_TICK:     jump = (op_q == OP_TICK);
      C_OP_BAD:      jump = (op_q > OP_TICK);
      C_CH_BAD_CMD:  jump = (op_q != OP_INIT) && !ch_ok;
      C_RAMP_ACTIVE: jump = ramp_active_q;
      C_OP_INIT:     jump = (op_q == OP_INIT);
      C_LVL_EQ_TGT:  jump = (cur_lvl == tgt_q);
      C_MODE_PWM:    jump = (cur_mode != MODE_ON) && (cur_mode != MODE_OFF);
      C_PERIOD_ZERO: jump = (ramp_period_q == 16'd0);
      C_OP_LEVEL:    jump = (op_q == OP_LEVEL);
      C_MODE_EQ_FM:  jump = (cur_mode == fm_q);
      C_EMITTED:     jump = emitted_q;
      C_RAMP_IDLE:   jump = !ramp_active_q;
      C_TICK_SHORT:  jump = (tick_q < ramp_period_q);
      C_CH_BAD:      jump = !ch_ok;
      C_PEND_NONE:   jump = (pend_q == PEND_NONE);
      default:       jump = 1'b1;
    endcase
  end

  always_comb begin
    emit_en   = 1'b0;
    emit_rec  = '0;
    lvl_we    = 1'b0;
    lvl_wd    = 8'h00;
    mode_we   = 1'b0;
    mode_wd   = MODE_PWM;
    clear_all = 1'b0;
    case (uw.act)
      A_EMIT_ST0: begin
        emit_en         = 1'b1;
        emit_rec.status = ST_OK;
      end
      A_EMIT_ST1: begin
        emit_en         = 1'b1;
        emit_rec.status = ST_BAD_CHAN;
      end
      A_EMIT_ST2: begin
        emit_en         = 1'b1;
        emit_rec.status = ST_BUSY;
      end
      A_EMIT_RESET: begin
        emit_en             = 1'b1;
        emit_rec.write_kind = KIND_RESET;
        emit_rec.bus_address = GENERAL_CALL;
        emit_rec.write_data = RESET_BYTE;
        clear_all           = 1'b1;
      end
      A_EMIT_IREF: begin
        emit_en                   = 1'b1;
        emit_rec.write_kind       = KIND_FULL;
        emit_rec.bus_address      = dev_addr_q;
        emit_rec.register_address = REG_IREF_ALL;
        emit_rec.write_data       = cur_scale_q;
        emit_rec.write_mask       = 8'hFF;
      end
      A_EMIT_DUTY_V, A_EMIT_DUTY_TGT, A_RAMP_START, A_RAMP_STEP: begin
        emit_en                   = 1'b1;
        emit_rec.write_kind       = KIND_FULL;
        emit_rec.bus_address      = dev_addr_q;
        emit_rec.register_address = duty_reg;
        emit_rec.write_mask       = 8'hFF;
        lvl_we                    = 1'b1;
        if (uw.act == A_EMIT_DUTY_V) begin
          lvl_wd = direct_v;
        end else if (uw.act == A_EMIT_DUTY_TGT) begin
          lvl_wd = tgt_q;
        end else begin
          lvl_wd = step_lvl;
        end
        emit_rec.write_data = lvl_wd;
      end
      A_SET_PWM, A_SET_MODE: begin
        emit_en                   = 1'b1;
        emit_rec.write_kind       = KIND_MASKED;
        emit_rec.bus_address      = dev_addr_q;
        emit_rec.register_address = mode_reg;
        emit_rec.write_data       = 8'({6'b000000, set_m} << mode_sh);
        emit_rec.write_mask       = 8'(8'h03 << mode_sh);
        mode_we                   = 1'b1;
        mode_wd                   = set_m;
        if (set_m == MODE_ON) begin
          lvl_we = 1'b1;
          lvl_wd = FULL_LEVEL;
        end else if (set_m == MODE_OFF) begin
          lvl_we = 1'b1;
          lvl_wd = 8'h00;
        end
      end
      default: begin
      end
    endcase
  end

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q    <= '0;
      ramp_period_q <= '0;
      cur_scale_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_DEVICE_ADDRESS: dev_addr_q    <= cfg_wdata_i[6:0];
        CFG_RAMP_PERIOD:    ramp_period_q <= cfg_wdata_i;
        CFG_CURRENT_SCALE:  cur_scale_q   <= cfg_wdata_i[7:0];
        default: begin
        end
      endcase
    end
  end

  // channel caches
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        level_q[i] <= 8'h00;
        mode_q[i]  <= MODE_PWM;
      end
    end else if (busy_q) begin
      if (clear_all) begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          level_q[i] <= 8'h00;
          mode_q[i]  <= MODE_PWM;
        end
      end else if (ch_ok) begin
        if (lvl_we) begin
          level_q[ch_idx] <= lvl_wd;
        end
        if (mode_we) begin
          mode_q[ch_idx] <= mode_wd;
        end
      end
    end
  end

  // sequencer, ramp state and result path
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_active_q <= 1'b0;
      ramp_ch_q     <= '0;
      ramp_tgt_q    <= '0;
      pend_q        <= PEND_NONE;
      tick_q        <= '0;
      busy_q        <= 1'b0;
      pc_q          <= S_DISPATCH;
      op_q          <= '0;
      ch_q          <= '0;
      tgt_q         <= '0;
      fm_q          <= MODE_OFF;
      emitted_q     <= 1'b0;
      hold_q        <= '0;
      hold_valid_q  <= 1'b0;
      res_q         <= '0;
      res_valid_q   <= 1'b0;
    end else begin
      res_valid_q <= flush;
      if (accept) begin
        busy_q    <= 1'b1;
        pc_q      <= S_DISPATCH;
        op_q      <= cmd_i.opcode;
        ch_q      <= cmd_i.channel;
        emitted_q <= 1'b0;
        if (cmd_i.opcode == OP_LEVEL) begin
          tgt_q <= cmd_i.level;
        end else if (cmd_i.opcode == OP_ON) begin
          tgt_q <= FULL_LEVEL;
        end else begin
          tgt_q <= 8'h00;
        end
        fm_q <= (cmd_i.opcode == OP_ON) ? MODE_ON : MODE_OFF;
      end else if (busy_q) begin
        pc_q <= jump ? uw.target : (pc_q + 6'd1);
        if (emit_en) begin
          hold_q       <= emit_rec;
          hold_valid_q <= 1'b1;
          emitted_q    <= 1'b1;
          if (hold_valid_q) begin
            res_q <= hold_q;
          end
        end
        case (uw.act)
          A_EMIT_RESET: begin
            ramp_active_q <= 1'b0;
            ramp_ch_q     <= '0;
            ramp_tgt_q    <= '0;
            pend_q        <= PEND_NONE;
            tick_q        <= '0;
          end
          A_RAMP_START: begin
            ramp_active_q <= 1'b1;
            ramp_ch_q     <= ch_q;
            ramp_tgt_q    <= tgt_q;
            tick_q        <= '0;
            if (op_q == OP_ON) begin
              pend_q <= PEND_ON;
            end else if (op_q == OP_OFF) begin
              pend_q <= PEND_OFF;
            end else begin
              pend_q <= PEND_NONE;
            end
          end
          A_TICK_INC: begin
            tick_q <= tick_q + 16'd1;
          end
          A_TICK_WRAP: begin
            tick_q <= '0;
            ch_q   <= ramp_ch_q;
            tgt_q  <= ramp_tgt_q;
          end
          A_RAMP_END: begin
            ramp_active_q <= 1'b0;
            pend_q        <= PEND_NONE;
            fm_q          <= (pend_q == PEND_ON) ? MODE_ON : MODE_OFF;
          end
          A_RAMP_ABORT: begin
            ramp_active_q <= 1'b0;
            pend_q        <= PEND_NONE;
          end
          A_FINISH: begin
            busy_q       <= 1'b0;
            hold_valid_q <= 1'b0;
            if (hold_valid_q) begin
              res_q <= last_rec;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign busy        = busy_q;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_res_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(busy_q))
    else $error("result strobe without a command in progress");

  a_ramp_channel_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ramp_active_q |-> ({1'b0, ramp_ch_q} < CH_LIMIT))
    else $error("ramp running on an invalid channel");

  a_pc_in_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (pc_q <= S_DONE))
    else $error("step counter beyond the program");

  a_hold_flushed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> !hold_valid_q)
    else $error("result left in hold buffer after command end");

endmodule

### tb/led_channel_write_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_channel_write_sequencer_tb
// Self-checking bench for the LED channel write sequencer.
// A queue-fed driver presents commands with random gaps, a monitor compares
// every result strobe with the writes predicted from a cycle-free copy of the
// channel caches and ramp state. Register settings change between phases
// while the block is idle: directed commands first, then random traffic.
// ----------------------------------------------------------------------------
module led_channel_write_sequencer_tb;
  import lcws_pkg::*;

  localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        start       = 1'b0;
  cmd_t        cmd_i       = '0;
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_addr_i  = '0;
  logic [15:0] cfg_wdata_i = '0;
  logic        busy;
  logic        res_valid_o;
  res_t        res_o;

  led_channel_write_sequencer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // register copies
  logic [6:0]  dev_addr;
  logic [15:0] ramp_len;
  logic [7:0]  iref_val;

  // cache and ramp copies
  logic [7:0]  duty_mem [NUM_CHANNELS];
  mode_e       mode_mem [NUM_CHANNELS];
  logic        ramping;
  logic [4:0]  ramp_ch;
  logic [7:0]  ramp_goal;
  pend_e       pend_mode;
  logic [15:0] tick_cnt;

  cmd_t cmd_q [$];
  res_t burst [$];
  res_t want_q [$];
  res_t wanted;

  int n_taken    = 0;
  int n_ticks    = 0;
  int n_checked  = 0;
  int n_bad      = 0;
  int n_steps    = 0;
  int n_settings = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("timeout: %0d requests still expected", want_q.size());
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  function automatic void put(kind_e k, logic [6:0] bus, logic [7:0] ra, logic [7:0] d,
                              logic [7:0] m, status_e s);
    res_t r;
    if (burst.size() >= 4) return;
    r.write_kind       = k;
    r.bus_address      = bus;
    r.register_address = ra;
    r.write_data       = d;
    r.write_mask       = m;
    r.status           = s;
    r.last             = 1'b0;
    burst.push_back(r);
  endfunction

  function automatic void put_full(logic [7:0] ra, logic [7:0] d);
    put(KIND_FULL, dev_addr, ra, d, 8'hFF, ST_OK);
  endfunction

  function automatic void change_mode(int ch, mode_e m);
    int sh;
    if (mode_mem[ch] == m) return;
    sh = (ch % 4) * 2;
    put(KIND_MASKED, dev_addr, REG_MODE0 + 8'(ch / 4), 8'(m) << sh, 8'd3 << sh, ST_OK);
    if (m == MODE_ON) duty_mem[ch] = FULL_LEVEL;
    else if (m == MODE_OFF) duty_mem[ch] = 8'h00;
    mode_mem[ch] = m;
  endfunction

  function automatic void step_duty(int ch);
    if (duty_mem[ch] > ramp_goal) duty_mem[ch] = duty_mem[ch] - 8'd1;
    else duty_mem[ch] = duty_mem[ch] + 8'd1;
    put_full(REG_DUTY0 + 8'(ch), duty_mem[ch]);
    n_steps++;
  endfunction

  // returns 1 when a ramp was started
  function automatic bit go_level(int ch, logic [7:0] lv);
    logic [7:0] v;
    if (duty_mem[ch] == lv) return 1'b0;
    if (mode_mem[ch] != MODE_PWM) begin
      v = (mode_mem[ch] == MODE_ON) ? FULL_LEVEL : 8'h00;
      put_full(REG_DUTY0 + 8'(ch), v);
      change_mode(ch, MODE_PWM);
      duty_mem[ch] = v;
    end
    if (ramp_len == 16'd0) begin
      put_full(REG_DUTY0 + 8'(ch), lv);
      duty_mem[ch] = lv;
      return 1'b0;
    end
    if (duty_mem[ch] == lv) return 1'b0;
    ramp_goal = lv;
    ramp_ch   = 5'(ch);
    ramping   = 1'b1;
    tick_cnt  = '0;
    pend_mode = PEND_NONE;
    step_duty(ch);
    return 1'b1;
  endfunction

  function automatic void tick_model();
    if (!ramping) return;
    tick_cnt = tick_cnt + 16'd1;
    if (tick_cnt < ramp_len) return;
    tick_cnt = '0;
    if (ramp_ch >= NUM_CHANNELS) begin
      ramping   = 1'b0;
      pend_mode = PEND_NONE;
      return;
    end
    if (duty_mem[ramp_ch] != ramp_goal) begin
      step_duty(ramp_ch);
      return;
    end
    ramping = 1'b0;
    if (pend_mode == PEND_ON) change_mode(ramp_ch, MODE_ON);
    else if (pend_mode == PEND_OFF) change_mode(ramp_ch, MODE_OFF);
    pend_mode = PEND_NONE;
  endfunction

  function automatic void clear_caches();
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      duty_mem[i] = 8'h00;
      mode_mem[i] = MODE_PWM;
    end
    ramping   = 1'b0;
    ramp_ch   = '0;
    ramp_goal = '0;
    pend_mode = PEND_NONE;
    tick_cnt  = '0;
  endfunction

  function automatic void predict_writes(cmd_t c);
    int ch;
    ch = int'(c.channel);
    burst.delete();
    if (c.opcode == OP_TICK) begin
      tick_model();
    end else if (c.opcode <= OP_OFF) begin
      if (c.opcode != OP_INIT && ch >= NUM_CHANNELS) begin
        put(KIND_STATUS, 7'd0, 8'd0, 8'd0, 8'd0, ST_BAD_CHAN);
      end else if (ramping) begin
        put(KIND_STATUS, 7'd0, 8'd0, 8'd0, 8'd0, ST_BUSY);
      end else if (c.opcode == OP_INIT) begin
        put(KIND_RESET, GENERAL_CALL, 8'd0, RESET_BYTE, 8'd0, ST_OK);
        clear_caches();
        put_full(REG_IREF_ALL, iref_val);
      end else if (c.opcode == OP_LEVEL) begin
        void'(go_level(ch, c.level));
      end else if (c.opcode == OP_ON) begin
        if (go_level(ch, FULL_LEVEL)) pend_mode = PEND_ON;
        else change_mode(ch, MODE_ON);
      end else begin
        if (go_level(ch, 8'h00)) pend_mode = PEND_OFF;
        else change_mode(ch, MODE_OFF);
      end
      if (burst.size() == 0) put(KIND_STATUS, 7'd0, 8'd0, 8'd0, 8'd0, ST_OK);
    end
    if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
    foreach (burst[i]) want_q.push_back(burst[i]);
  endfunction

  // ------------------------------------------------------------------- driver
  always @(posedge clk_i or negedge rst_ni) begin : drv_proc
    logic took;
    logic quiet;
    if (!rst_ni) begin
      start <= 1'b0;
      cmd_i <= '0;
    end else begin
      took = start && !busy;
      if (took) begin
        predict_writes(cmd_i);
        n_taken++;
        if (cmd_i.opcode == OP_TICK) n_ticks++;
      end
      quiet = (n_taken >= 120 && n_taken < 170);
      if (!start || took) begin
        if (cmd_q.size() > 0 && (quiet || $urandom_range(99) >= 22)) begin
          start <= 1'b1;
          cmd_i <= cmd_q.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------ monitor
  function automatic string show(res_t r);
    return $sformatf("kind=%0d bus=%02h reg=%02h data=%02h mask=%02h st=%0d last=%0b",
                     r.write_kind, r.bus_address, r.register_address, r.write_data,
                     r.write_mask, r.status, r.last);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (want_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("%0t unexpected request: %s", $realtime, show(res_o));
      end else begin
        wanted = want_q.pop_front();
        n_checked++;
        if (res_o.write_kind       !== wanted.write_kind       ||
            res_o.bus_address      !== wanted.bus_address      ||
            res_o.register_address !== wanted.register_address ||
            res_o.write_data       !== wanted.write_data       ||
            res_o.write_mask       !== wanted.write_mask       ||
            res_o.status           !== wanted.status           ||
            res_o.last             !== wanted.last) begin
          n_bad++;
          if (n_bad <= 10) begin
            $display("%0t request mismatch", $realtime);
            $display("  expected %s", show(wanted));
            $display("  actual   %s", show(res_o));
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic void add(logic [2:0] op, int ch, int lv);
    cmd_t c;
    c.opcode  = op;
    c.channel = 5'(ch);
    c.level   = 8'(lv);
    cmd_q.push_back(c);
  endfunction

  task automatic fill_random(int n, bit short_ramps);
    int r;
    int ch;
    int lv;
    logic [2:0] op;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 4) op = OP_INIT;
      else if (r < (short_ramps ? 34 : 50)) op = OP_LEVEL;
      else if (r < (short_ramps ? 36 : 65)) op = OP_ON;
      else if (r < (short_ramps ? 46 : 80)) op = OP_OFF;
      else if (r < (short_ramps ? 95 : 90)) op = OP_TICK;
      else op = OP_FIRST_UNUSED + 3'($urandom_range(2));
      if ($urandom_range(99) < 8) ch = $urandom_range(31, NUM_CHANNELS);
      else if (short_ramps) ch = $urandom_range(7);
      else ch = $urandom_range(NUM_CHANNELS - 1);
      if (short_ramps) lv = $urandom_range(7);
      else if ($urandom_range(9) == 0) lv = $urandom_range(1) ? 255 : 0;
      else lv = $urandom_range(255);
      add(op, ch, lv);
    end
  endtask

  task automatic set_regs(logic [6:0] addr, logic [15:0] period, logic [7:0] scale);
    dev_addr = addr;
    ramp_len = period;
    iref_val = scale;
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= CFG_DEVICE_ADDRESS;
    cfg_wdata_i <= 16'(addr);
    @(posedge clk_i);
    cfg_addr_i  <= CFG_RAMP_PERIOD;
    cfg_wdata_i <= period;
    @(posedge clk_i);
    cfg_addr_i  <= CFG_CURRENT_SCALE;
    cfg_wdata_i <= 16'(scale);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    n_settings++;
    @(negedge clk_i);
  endtask

  // ticks may leave no request behind, so allow a full program path after
  task automatic wait_drained();
    do @(negedge clk_i);
    while (cmd_q.size() != 0 || start || busy || want_q.size() != 0);
    repeat (20) @(negedge clk_i);
  endtask

  initial begin
    dev_addr = '0;
    ramp_len = '0;
    iref_val = '0;
    clear_caches();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // direct writes, mode changes, bad channels, unused opcodes
    set_regs(7'h2A, 16'd0, 8'hFF);
    add(OP_INIT, 31, 255);
    add(OP_LEVEL, 0, 200);
    add(OP_LEVEL, 0, 200);
    add(OP_ON, 23, 0);
    add(OP_LEVEL, 23, 100);
    add(OP_OFF, 5, 0);
    add(OP_ON, 5, 0);
    add(OP_LEVEL, NUM_CHANNELS, 1);
    add(OP_ON, 31, 0);
    add(OP_OFF, 30, 0);
    add(OP_FIRST_UNUSED, 31, 255);
    add(OP_LAST_UNUSED, 0, 0);
    add(OP_TICK, 0, 0);
    add(OP_LEVEL, 6, 253);
    add(OP_LEVEL, 7, 2);
    wait_drained();

    // ramps: busy, bad channel during a ramp, deferred on and off
    set_regs(7'h7F, 16'd1, 8'h00);
    add(OP_LEVEL, 1, 2);
    add(OP_LEVEL, 4, 9);
    add(OP_INIT, 0, 0);
    add(OP_ON, 27, 0);
    add(OP_TICK, 0, 0);
    add(OP_TICK, 0, 0);
    add(OP_ON, 6, 0);
    add(OP_TICK, 0, 0);
    add(OP_TICK, 0, 0);
    add(OP_OFF, 7, 0);
    add(OP_TICK, 0, 0);
    add(OP_TICK, 0, 0);
    wait_drained();

    set_regs(7'h00, 16'd0, 8'h3C);
    fill_random(60, 1'b0);
    wait_drained();

    set_regs(7'h7F, 16'd1, 8'hFF);
    add(OP_INIT, 0, 0);
    fill_random(60, 1'b1);
    wait_drained();

    set_regs(7'($urandom), 16'd3, 8'($urandom));
    fill_random(60, 1'b1);
    wait_drained();

    // longest period; a ramp left hanging here is cut short by the next setting
    set_regs(7'($urandom), 16'hFFFF, 8'($urandom));
    add(OP_INIT, 0, 0);
    add(OP_LEVEL, 3, 7);
    fill_random(8, 1'b1);
    wait_drained();

    set_regs(7'($urandom), 16'd2, 8'h00);
    fill_random(50, 1'b1);
    wait_drained();

    $display("%0d commands (%0d ticks) under %0d register settings", n_taken, n_ticks,
             n_settings);
    $display("%0d requests checked, %0d ramp steps, %0d mismatches", n_checked, n_steps,
             n_bad);
    if (n_bad == 0 && want_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
